// ----- rtl/asbs_pkg.sv -----
// Shared widths, command codes and register indexes for the additive sine bank synthesizer.
package asbs_pkg;

  localparam int unsigned COMMAND_W   = 2;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned FREQ_W      = 24;
  localparam int unsigned AMP_W       = 16;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned RATE_W      = 18;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 18;

  // The modulus is the sample rate times 256, matching the Q16.8 frequency.
  localparam int unsigned DEN_W  = RATE_W + 8;
  localparam int unsigned PROD_W = FREQ_W + PHASE_W;

  // Remainder steps taken per clock by the serial divider.
  localparam int unsigned STEPS_PER_CYCLE = 4;

  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RESET = RATE_W'(44100);
  localparam logic [SCALE_W-1:0] AMP_SCALE_RESET   = SCALE_W'(256);

  // Quarter turn in Q30 and one in Q30, used to build the sine table.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1073741824;

  typedef enum logic [COMMAND_W-1:0] {
    CMD_WRITE_SLOT = 2'd0,
    CMD_SET_COUNT  = 2'd1,
    CMD_LOAD_PHASE = 2'd2,
    CMD_EMIT       = 2'd3
  } cmd_t;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_AMP_SCALE   = 1'b1;

endpackage

// ----- rtl/additive_sine_bank_synth.sv -----
// Top level of the additive sine bank synthesizer: harmonic store, serial divider and mixer.

// Additive synthesizer over a bank of harmonic slots. A transaction on start/busy carries one
// command: write a slot (frequency Q16.8 Hz, amplitude Q8.8), set the number of active slots,
// load the phase counter, or emit a sample. The first three complete at the accepting edge and
// never raise busy. An emit raises busy while the active slots are walked one at a time from
// slot 0: each slot is read from the harmonic memory, its frequency is multiplied by the phase,
// the product is reduced modulo 256 * sample_rate and scaled to a sine table index by a serial
// restoring divider taking four steps per clock, and amp * sine is added to an accumulator.
// The summed value is multiplied by amp_scale, divided by 2^31 truncating toward zero, saturated
// to 16 bits and presented on sample and clipped together with a one-cycle done strobe. The
// receiver cannot hold results off, so done must be captured in the cycle it is high; busy is
// already low in that cycle and the next command may be accepted then. The phase counter
// advances by one after every emitted sample and wraps modulo 2^32. The configuration channel
// is always ready; sample_rate and amp_scale should be written only while the block is idle,
// and a sample rate of zero acts as one. Slots are undefined until written and should be
// written before they are made active.
module additive_sine_bank_synth
  import asbs_pkg::*;
#(
  parameter int unsigned MAX_HARMONICS = 64,
  parameter int unsigned TABLE_SIZE    = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [COMMAND_W-1:0]       command,
  input  logic [SLOT_W-1:0]          slot,
  input  logic [FREQ_W-1:0]          freq_hz,
  input  logic [AMP_W-1:0]           amplitude,
  input  logic [COUNT_W-1:0]         active_count,
  input  logic [PHASE_W-1:0]         start_phase,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] sample,
  output logic                       clipped,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  // Derived sizes.
  localparam int unsigned AW     = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
  localparam int unsigned SW     = (AW > SLOT_W) ? AW : SLOT_W;
  localparam int unsigned CW     = $clog2(MAX_HARMONICS + 1);
  localparam int unsigned QB     = $clog2(TABLE_SIZE);
  localparam int unsigned SC_W   = DEN_W + QB;
  localparam int unsigned SL_W   = $clog2(PROD_W + 1);
  localparam int unsigned MEM_W  = FREQ_W + AMP_W;
  localparam int unsigned TERM_W = AMP_W + SAMPLE_W + 1;
  localparam int unsigned ACC_W  = TERM_W + CW;
  localparam int unsigned PW     = ACC_W + SCALE_W + 1;
  localparam int unsigned QW     = PW - 31;

  localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN = QW'(-32768);

  // Sine table, one period of round(32767 * sin(2 * pi * k / TABLE_SIZE)), built at
  // elaboration by quadrant folding and a Q30 Taylor series.
  typedef logic signed [SAMPLE_W-1:0] sine_table_t [TABLE_SIZE];

  function automatic sine_table_t build_sine();
    sine_table_t      tbl;
    longint unsigned  p;
    longint unsigned  a;
    longint unsigned  x;
    longint unsigned  x2;
    longint unsigned  term;
    longint           sum;
    longint           mag;
    bit               neg;
    for (int unsigned k = 0; k < TABLE_SIZE; k++) begin
      p   = 64'(4 * k);
      neg = 1'b0;
      if (p < 64'(TABLE_SIZE)) begin
        a = p;
      end else if (p < 64'(2 * TABLE_SIZE)) begin
        a = 64'(2 * TABLE_SIZE) - p;
      end else if (p < 64'(3 * TABLE_SIZE)) begin
        a   = p - 64'(2 * TABLE_SIZE);
        neg = 1'b1;
      end else begin
        a   = 64'(4 * TABLE_SIZE) - p;
        neg = 1'b1;
      end
      x    = a * HALF_PI_Q30 / TABLE_SIZE;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int j = 1; j <= 5; j++) begin
        term = (term * x2) >> 30;
        case (j)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          default: term = term / 110;
        endcase
        if (j % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      mag = (sum * 32767 + ONE_Q30 / 2) >>> 30;
      if (mag > 32767) begin
        mag = 32767;
      end
      tbl[k] = neg ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
    end
    return tbl;
  endfunction

  localparam sine_table_t SINE_ROM = build_sine();

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_MOD,
    S_SCALE,
    S_IDX,
    S_ROM,
    S_TERM,
    S_ACC,
    S_FIN_MUL,
    S_FIN_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [RATE_W-1:0]  sample_rate;
  logic [SCALE_W-1:0] amp_scale;

  // Architectural state outside the memory.
  logic [CW-1:0]      harmonic_total;
  logic [PHASE_W-1:0] phase;

  // Datapath registers.
  logic [CW-1:0]            slot_idx;
  logic [PROD_W-1:0]        dvd;
  logic [DEN_W-1:0]         rem;
  logic [QB-1:0]            quo;
  logic [SL_W-1:0]          step_left;
  logic signed [SAMPLE_W-1:0] rom_q;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PW-1:0]     prod;

  // Harmonic memory, frequency in the upper bits and amplitude in the lower bits.
  logic [MEM_W-1:0] harm_mem [MAX_HARMONICS];
  logic [MEM_W-1:0] mem_q;
  logic [FREQ_W-1:0] mem_freq;
  logic [AMP_W-1:0]  mem_amp;

  logic              accept;
  cmd_t              cmd;
  logic              wr_en;
  logic [SW-1:0]     slot_wide;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [DEN_W-1:0]  den;
  logic [RATE_W-1:0] rate_eff;

  logic [DEN_W-1:0]  rem_next;
  logic [PROD_W-1:0] dvd_next;
  logic [QB-1:0]     quo_next;
  logic [SL_W-1:0]   step_left_next;
  logic              steps_last;
  logic [SC_W-1:0]   scaled;

  logic signed [QW-1:0] q_floor;
  logic signed [QW-1:0] q_trunc;
  logic                 round_up;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cmd       = cmd_t'(command);

  assign slot_wide = SW'(slot);
  assign wr_addr   = slot_wide[AW-1:0];
  assign wr_en     = accept && (cmd == CMD_WRITE_SLOT) && (32'(slot) < MAX_HARMONICS);
  assign rd_en     = (state == S_READ);
  assign mem_freq  = mem_q[MEM_W-1:AMP_W];
  assign mem_amp   = mem_q[AMP_W-1:0];

  // A zero rate is treated as one so that the modulus never vanishes.
  assign rate_eff = (sample_rate == '0) ? RATE_W'(1) : sample_rate;
  assign den      = {rate_eff, 8'b0};

  // Remainder times the table size; the quotient of this by den is the table index.
  assign scaled = SC_W'(rem) * SC_W'(TABLE_SIZE);

  // Restoring division steps, several per clock. The dividend bits are shifted out of the top
  // of dvd into the remainder; quotient bits collect in quo.
  always_comb begin
    logic [DEN_W:0] trial;
    trial    = '0;
    rem_next = rem;
    dvd_next = dvd;
    quo_next = quo;
    for (int k = 0; k < STEPS_PER_CYCLE; k++) begin
      if (SL_W'(k) < step_left) begin
        trial    = {rem_next, dvd_next[PROD_W-1]};
        dvd_next = {dvd_next[PROD_W-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem_next = DEN_W'(trial - {1'b0, den});
          quo_next = {quo_next[QB-2:0], 1'b1};
        end else begin
          rem_next = trial[DEN_W-1:0];
          quo_next = {quo_next[QB-2:0], 1'b0};
        end
      end
    end
    steps_last     = (step_left <= SL_W'(STEPS_PER_CYCLE));
    step_left_next = steps_last ? '0 : step_left - SL_W'(STEPS_PER_CYCLE);
  end

  // Final scaling: divide by 2^31 truncating toward zero.
  assign q_floor  = $signed(prod[PW-1:31]);
  assign round_up = prod[PW-1] && (prod[30:0] != '0);
  assign q_trunc  = q_floor + QW'(round_up);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SAMPLE_RATE_RESET;
      amp_scale   <= AMP_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate <= cfg_data[RATE_W-1:0];
        REG_AMP_SCALE:   amp_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Harmonic memory: one write port from the command channel, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      harm_mem[wr_addr] <= {freq_hz, amplitude};
    end
    if (rd_en) begin
      mem_q <= harm_mem[slot_idx[AW-1:0]];
    end
  end

  // Sine table read, registered.
  always_ff @(posedge clk) begin
    if (state == S_ROM) begin
      rom_q <= SINE_ROM[quo];
    end
  end

  // Sequencer and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      harmonic_total <= '0;
      phase          <= '0;
      done           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_SET_COUNT: begin
                harmonic_total <= (32'(active_count) > MAX_HARMONICS) ?
                                  CW'(MAX_HARMONICS) : CW'(active_count);
              end
              CMD_LOAD_PHASE: begin
                phase <= start_phase;
              end
              CMD_EMIT: begin
                acc      <= '0;
                slot_idx <= '0;
                state    <= (harmonic_total == '0) ? S_FIN_MUL : S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          state <= S_MUL;
        end
        S_MUL: begin
          dvd       <= PROD_W'(mem_freq) * PROD_W'(phase);
          rem       <= '0;
          step_left <= SL_W'(PROD_W);
          state     <= S_MOD;
        end
        S_MOD: begin
          dvd       <= dvd_next;
          rem       <= rem_next;
          quo       <= quo_next;
          step_left <= step_left_next;
          if (steps_last) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: begin
          // The upper part of the scaled remainder is already below den, so only the
          // index bits remain to be divided out.
          rem       <= scaled[SC_W-1:QB];
          dvd       <= {scaled[QB-1:0], {(PROD_W - QB){1'b0}}};
          quo       <= '0;
          step_left <= SL_W'(QB);
          state     <= S_IDX;
        end
        S_IDX: begin
          dvd       <= dvd_next;
          rem       <= rem_next;
          quo       <= quo_next;
          step_left <= step_left_next;
          if (steps_last) begin
            state <= S_ROM;
          end
        end
        S_ROM: begin
          state <= S_TERM;
        end
        S_TERM: begin
          term  <= $signed({1'b0, mem_amp}) * rom_q;
          state <= S_ACC;
        end
        S_ACC: begin
          acc      <= acc + ACC_W'(term);
          slot_idx <= slot_idx + 1'b1;
          state    <= (slot_idx + 1'b1 == harmonic_total) ? S_FIN_MUL : S_READ;
        end
        S_FIN_MUL: begin
          prod  <= acc * $signed({1'b0, amp_scale});
          state <= S_FIN_OUT;
        end
        S_FIN_OUT: begin
          if (q_trunc > Q_MAX) begin
            sample  <= SAMPLE_W'(Q_MAX);
            clipped <= 1'b1;
          end else if (q_trunc < Q_MIN) begin
            sample  <= SAMPLE_W'(Q_MIN);
            clipped <= 1'b1;
          end else begin
            sample  <= q_trunc[SAMPLE_W-1:0];
            clipped <= 1'b0;
          end
          done  <= 1'b1;
          phase <= phase + 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A result only ever follows a cycle in which an emit was in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an emit in progress");

  // An accepted emit holds the block busy in the next cycle.
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_EMIT) |=> busy)
    else $error("emit accepted but block not busy");

  // The phase moves on by exactly one with every result.
  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    done |-> (phase == $past(phase) + 1'b1))
    else $error("phase did not advance by one with a result");

  // A clipped result sits on one of the rails.
  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    (done && clipped) |-> (sample == 16'sh7fff || sample == -16'sh8000))
    else $error("clipped result not at a rail");

  // The divider never produces an index outside the sine table.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROM) |-> (32'(quo) < TABLE_SIZE))
    else $error("sine table index out of range");

endmodule
